>>> sv/lwsc_pkg.sv
// shared types and constants of the lru write-back sector cache
// no dependencies; used by the slot cell, the stack cell and the top level
`timescale 1ns / 1ps
package lwsc_pkg;

  localparam int CAPACITY    = 32;
  localparam int SECTOR_BITS = 32;
  localparam int RUN_MAX     = 512;
  localparam int SLOT_W      = $clog2(CAPACITY);
  localparam int RANK_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int LIMIT_W     = 10;

  // input kinds
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_MODIFY = 2'd2;
  localparam logic [1:0] KIND_FLUSH  = 2'd3;

  // result ops
  localparam logic [1:0] OP_ACCESS = 2'd0;
  localparam logic [1:0] OP_FILL   = 2'd1;
  localparam logic [1:0] OP_WBACK  = 2'd2;
  localparam logic [1:0] OP_FLUSH  = 2'd3;

  // config register indexes
  localparam logic REG_ENABLED = 1'b0;
  localparam logic REG_LIMIT   = 1'b1;

  typedef logic [2:0] cell_op_t;
  localparam cell_op_t CELL_NONE    = 3'd0;
  localparam cell_op_t CELL_MRU     = 3'd1;
  localparam cell_op_t CELL_INSERT  = 3'd2;
  localparam cell_op_t CELL_REPLACE = 3'd3;
  localparam cell_op_t CELL_CLEAN   = 3'd4;
  localparam cell_op_t CELL_INVAL   = 3'd5;

  typedef struct packed {
    cell_op_t                op;
    logic                    by_rank;
    logic [SECTOR_BITS-1:0]  key_tag;
    logic [RANK_W-1:0]       key_rank;
    logic [RANK_W-1:0]       sel_rank;
    logic                    set_dirty;
  } cell_cmd_t;

endpackage

>>> sv/lru_writeback_sector_cache.sv
// top level of the lru write-back sector cache: controller, slot cells, free stack
// depends on lwsc_pkg, lwsc_slot_cell, lwsc_stack_cell
`timescale 1ns / 1ps
//
// channel | dir | tdata                                   | tuser | tlast
// in_     | in  | sector[31:0]                            | kind  | request_end
// out_    | out | hit,slot,start_sector,run_count,        | op    | last
//         |     | refused,request_end_res (from bit 0)    |       |
// cfg_    | in  | we, addr (register index), wdata        |       |
//
// a hit makes its slot the most recent; a miss takes a free slot and fills it unless the kind is write
// with no free slot the oldest is evicted; a dirty victim first writes back its run of dirty sectors
// (at most 32); flush all evicts every valid slot, writing back the run of each dirty one
// one item is worked at a time; the tag search is one broadcast compare over all cells
// reset is synchronous; state returns to empty with the free stack full
// a waiting result stalls only the states that emit; the output register decouples the sides
module lru_writeback_sector_cache (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,   // sector
  input  logic [1:0]                        in_tuser,   // kind
  input  logic                              in_tlast,   // request_end
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [55:0]                       out_tdata,  // hit, slot, start_sector,
                                                        // run_count, refused,
                                                        // request_end_res, zero pad
  output logic [1:0]                        out_tuser,  // op
  output logic                              out_tlast,  // last
  input  logic                              cfg_we,
  input  logic                              cfg_addr,
  input  logic [lwsc_pkg::LIMIT_W-1:0]      cfg_wdata
);
  import lwsc_pkg::*;

  // controller states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_REFUSE = 4'd1;
  localparam logic [3:0] ST_LOOK   = 4'd2;
  localparam logic [3:0] ST_DEC    = 4'd3;
  localparam logic [3:0] ST_HIT    = 4'd4;
  localparam logic [3:0] ST_INS    = 4'd5;
  localparam logic [3:0] ST_FILL   = 4'd6;
  localparam logic [3:0] ST_ACC    = 4'd7;
  localparam logic [3:0] ST_VICT   = 4'd8;
  localparam logic [3:0] ST_WB     = 4'd9;
  localparam logic [3:0] ST_WBOUT  = 4'd10;
  localparam logic [3:0] ST_REPL   = 4'd11;
  localparam logic [3:0] ST_FPROBE = 4'd12;
  localparam logic [3:0] ST_FINV   = 4'd13;
  localparam logic [3:0] ST_FDONE  = 4'd14;

  // configuration
  logic               enabled_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [LIMIT_W-1:0] lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      limit_r   <= LIMIT_W'(32);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ENABLED: enabled_r <= cfg_wdata[0];
        REG_LIMIT:   limit_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // effective run limit: zero acts as one, capped at the run maximum and capacity
  always_comb begin
    lim = limit_r;
    if (lim == '0) lim = LIMIT_W'(1);
    if (lim > LIMIT_W'(RUN_MAX)) lim = LIMIT_W'(RUN_MAX);
    if (lim > LIMIT_W'(CAPACITY)) lim = LIMIT_W'(CAPACITY);
  end

  // controller registers
  logic [3:0]             state_r, state_nxt;
  logic [1:0]             kind_r, kind_nxt;
  logic [SECTOR_BITS-1:0] sector_r, sector_nxt;
  logic                   rend_r, rend_nxt;
  logic [CNT_W-1:0]       free_count_r, free_count_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [SECTOR_BITS-1:0] base_r, base_nxt;
  logic [CNT_W-1:0]       run_r, run_nxt;
  logic [CAPACITY-1:0]    tgt_vec_r, tgt_vec_nxt;
  logic [RANK_W-1:0]      tgt_rank_r, tgt_rank_nxt;

  // probe results, registered every cycle
  logic                   prb_any_r, prb_dirty_r;
  logic [CAPACITY-1:0]    prb_vec_r;
  logic [SLOT_W-1:0]      prb_slot_r;
  logic [SECTOR_BITS-1:0] prb_tag_r;
  logic [RANK_W-1:0]      prb_rank_r;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_user_r, out_user_nxt;
  logic [55:0] out_data_r, out_data_nxt;
  logic        out_last_r, out_last_nxt;

  // cell row signals
  cell_cmd_t              cmd;
  logic [CAPACITY-1:0]    cell_sel;
  logic [CAPACITY-1:0]    cell_match;
  logic [CAPACITY-1:0]    cell_dirty;
  logic [SECTOR_BITS-1:0] cell_tag  [CAPACITY];
  logic [RANK_W-1:0]      cell_rank [CAPACITY];

  // free stack signals
  logic [SLOT_W-1:0]   stk [CAPACITY];
  logic [CAPACITY-1:0] stk_onehot;
  logic                push, pop;

  // combinational probe reduction; matches are unique among valid slots
  logic                   prb_any, prb_dirty, wb_hit;
  logic [SLOT_W-1:0]      prb_slot;
  logic [SECTOR_BITS-1:0] prb_tag;
  logic [RANK_W-1:0]      prb_rank;

  logic emit_go, emit;
  logic [1:0]             e_op;
  logic                   e_hit, e_refused, e_rend, e_last;
  logic [SECTOR_BITS-1:0] e_start;
  logic [LIMIT_W-1:0]     e_count;
  logic [SLOT_W-1:0]      e_slot;

  assign in_tready  = (state_r == ST_IDLE);
  assign emit_go    = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    prb_any   = 1'b0;
    prb_dirty = 1'b0;
    wb_hit    = 1'b0;
    prb_slot  = '0;
    prb_tag   = '0;
    prb_rank  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_match[i]) begin
        prb_any   = 1'b1;
        prb_dirty = prb_dirty | cell_dirty[i];
        prb_slot  = prb_slot | SLOT_W'(i);
        prb_tag   = prb_tag | cell_tag[i];
        prb_rank  = prb_rank | cell_rank[i];
      end
      wb_hit = wb_hit | (cell_match[i] & cell_dirty[i]);
    end
  end

  always_ff @(posedge clk) begin
    prb_any_r   <= prb_any;
    prb_dirty_r <= prb_dirty;
    prb_vec_r   <= cell_match;
    prb_slot_r  <= prb_slot;
    prb_tag_r   <= prb_tag;
    prb_rank_r  <= prb_rank;
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      stk_onehot[i] = (stk[0] == SLOT_W'(i));
    end
  end

  // broadcast command to the slot row
  always_comb begin
    cmd.op        = CELL_NONE;
    cmd.by_rank   = (state_r == ST_DEC) || (state_r == ST_FPROBE);
    cmd.key_tag   = (state_r == ST_WB) ? base_r + SECTOR_BITS'(run_r) : sector_r;
    // oldest valid slot has rank valid_count - 1
    cmd.key_rank  = (state_r == ST_DEC) ? RANK_W'(CAPACITY - 1)
                                        : RANK_W'(CNT_W'(CAPACITY - 1) - free_count_r);
    cmd.sel_rank  = tgt_rank_r;
    cmd.set_dirty = (kind_r != KIND_READ);
    case (state_r)
      ST_HIT:   if (emit_go) cmd.op = CELL_MRU;
      ST_INS:   cmd.op = CELL_INSERT;
      ST_REPL:  cmd.op = CELL_REPLACE;
      ST_FINV:  cmd.op = CELL_INVAL;
      ST_WB:    if (wb_hit && (LIMIT_W'(run_r) < lim)) cmd.op = CELL_CLEAN;
      default:  cmd.op = CELL_NONE;
    endcase
  end

  assign cell_sel = (state_r == ST_INS) ? stk_onehot : tgt_vec_r;

  // controller
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    sector_nxt     = sector_r;
    rend_nxt       = rend_r;
    free_count_nxt = free_count_r;
    slot_nxt       = slot_r;
    base_nxt       = base_r;
    run_nxt        = run_r;
    tgt_vec_nxt    = tgt_vec_r;
    tgt_rank_nxt   = tgt_rank_r;
    push           = 1'b0;
    pop            = 1'b0;
    emit           = 1'b0;
    e_op           = OP_ACCESS;
    e_hit          = 1'b0;
    e_refused      = 1'b0;
    e_rend         = 1'b0;
    e_last         = 1'b0;
    e_start        = '0;
    e_count        = '0;
    e_slot         = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          kind_nxt   = in_tuser;
          sector_nxt = in_tdata;
          rend_nxt   = in_tlast;
          if (!enabled_r) state_nxt = ST_REFUSE;
          else if (in_tuser == KIND_FLUSH) state_nxt = ST_FPROBE;
          else state_nxt = ST_LOOK;
        end
      end
      ST_REFUSE: begin
        if (emit_go) begin
          emit      = 1'b1;
          e_op      = (kind_r == KIND_FLUSH) ? OP_FLUSH : OP_ACCESS;
          e_refused = 1'b1;
          e_rend    = (kind_r == KIND_FLUSH) ? 1'b0 : rend_r;
          e_last    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_LOOK: begin
        state_nxt = ST_DEC;
      end
      ST_DEC: begin
        if (prb_any_r) begin
          tgt_vec_nxt  = prb_vec_r;
          tgt_rank_nxt = prb_rank_r;
          slot_nxt     = prb_slot_r;
          state_nxt    = ST_HIT;
        end else if (free_count_r != '0) begin
          state_nxt = ST_INS;
        end else begin
          state_nxt = ST_VICT;
        end
      end
      ST_HIT: begin
        if (emit_go) begin
          emit      = 1'b1;
          e_op      = OP_ACCESS;
          e_hit     = 1'b1;
          e_slot    = slot_r;
          e_rend    = rend_r;
          e_last    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_INS: begin
        pop            = 1'b1;
        free_count_nxt = free_count_r - 1'b1;
        slot_nxt       = stk[0];
        state_nxt      = (kind_r == KIND_WRITE) ? ST_ACC : ST_FILL;
      end
      ST_FILL: begin
        if (emit_go) begin
          emit      = 1'b1;
          e_op      = OP_FILL;
          e_slot    = slot_r;
          e_start   = sector_r;
          e_count   = LIMIT_W'(1);
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (emit_go) begin
          emit      = 1'b1;
          e_op      = OP_ACCESS;
          e_slot    = slot_r;
          e_rend    = rend_r;
          e_last    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_VICT: begin
        // victim is the oldest slot, found by the rank probe
        tgt_vec_nxt  = prb_vec_r;
        tgt_rank_nxt = prb_rank_r;
        slot_nxt     = prb_slot_r;
        base_nxt     = prb_tag_r;
        run_nxt      = '0;
        if (prb_dirty_r) state_nxt = ST_WB;
        else if (kind_r == KIND_FLUSH) state_nxt = ST_FINV;
        else state_nxt = ST_REPL;
      end
      ST_WB: begin
        // one sector of the run per cycle
        if (wb_hit && (LIMIT_W'(run_r) < lim)) run_nxt = run_r + 1'b1;
        else state_nxt = ST_WBOUT;
      end
      ST_WBOUT: begin
        if (emit_go) begin
          emit      = 1'b1;
          e_op      = OP_WBACK;
          e_slot    = slot_r;
          e_start   = base_r;
          e_count   = LIMIT_W'(run_r);
          state_nxt = (kind_r == KIND_FLUSH) ? ST_FINV : ST_REPL;
        end
      end
      ST_REPL: begin
        state_nxt = (kind_r == KIND_WRITE) ? ST_ACC : ST_FILL;
      end
      ST_FPROBE: begin
        if (free_count_r == CNT_W'(CAPACITY)) state_nxt = ST_FDONE;
        else state_nxt = ST_VICT;
      end
      ST_FINV: begin
        push           = 1'b1;
        free_count_nxt = free_count_r + 1'b1;
        state_nxt      = ST_FPROBE;
      end
      ST_FDONE: begin
        if (emit_go) begin
          emit      = 1'b1;
          e_op      = OP_FLUSH;
          e_last    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_user_nxt  = out_user_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_user_nxt  = e_op;
      out_last_nxt  = e_last;
      out_data_nxt  = {6'd0, e_rend, e_refused, e_count, e_start, e_slot, e_hit};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      free_count_r <= CNT_W'(CAPACITY);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_count_r <= free_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    sector_r   <= sector_nxt;
    rend_r     <= rend_nxt;
    slot_r     <= slot_nxt;
    base_r     <= base_nxt;
    run_r      <= run_nxt;
    tgt_vec_r  <= tgt_vec_nxt;
    tgt_rank_r <= tgt_rank_nxt;
    out_user_r <= out_user_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // row of slot cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
    lwsc_slot_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .sel   (cell_sel[g]),
      .match (cell_match[g]),
      .tag   (cell_tag[g]),
      .rank  (cell_rank[g]),
      .dirty (cell_dirty[g])
    );
  end

  // free stack as a shift chain, top at position 0
  for (genvar g = 0; g < CAPACITY; g++) begin : g_stack
    lwsc_stack_cell u_stk (
      .clk        (clk),
      .rst_n      (rst_n),
      .rst_val    (SLOT_W'(CAPACITY - 1 - g)),
      .push       (push),
      .pop        (pop),
      .from_above ((g == 0) ? slot_r : stk[(g == 0) ? 0 : g - 1]),
      .from_below (stk[(g == CAPACITY - 1) ? g : g + 1]),
      .entry      (stk[g])
    );
  end

  // tags and ranks of valid slots are unique
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cell_match))
    else $error("more than one slot matches the probe");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= CNT_W'(CAPACITY))
    else $error("free count above capacity");

  a_hit_target: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HIT) |-> $onehot(tgt_vec_r))
    else $error("hit without a single target slot");

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB) |-> (LIMIT_W'(run_r) <= lim))
    else $error("write-back run beyond limit");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != ST_IDLE))
    else $error("accepted transaction left no work");

endmodule

>>> sv/lwsc_slot_cell.sv
// one cache slot: tag, valid, dirty and recency rank with local update rules
// depends on lwsc_pkg
`timescale 1ns / 1ps
module lwsc_slot_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lwsc_pkg::cell_cmd_t               cmd,
  input  logic                              sel,
  output logic                              match,
  output logic [lwsc_pkg::SECTOR_BITS-1:0]  tag,
  output logic [lwsc_pkg::RANK_W-1:0]       rank,
  output logic                              dirty
);
  import lwsc_pkg::*;

  logic                   valid_r;
  logic                   dirty_r;
  logic [SECTOR_BITS-1:0] tag_r;
  logic [RANK_W-1:0]      rank_r;
  logic                   younger;

  assign younger = valid_r && (rank_r < cmd.sel_rank);
  assign match   = valid_r && (cmd.by_rank ? (rank_r == cmd.key_rank)
                                           : (tag_r == cmd.key_tag));
  assign tag     = tag_r;
  assign rank    = rank_r;
  assign dirty   = dirty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
    end else begin
      case (cmd.op)
        CELL_MRU: begin
          if (sel) dirty_r <= dirty_r | cmd.set_dirty;
        end
        CELL_INSERT, CELL_REPLACE: begin
          if (sel) begin
            valid_r <= 1'b1;
            dirty_r <= cmd.set_dirty;
          end
        end
        CELL_CLEAN: begin
          if (match) dirty_r <= 1'b0;
        end
        CELL_INVAL: begin
          if (sel) begin
            valid_r <= 1'b0;
            dirty_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_MRU, CELL_REPLACE: begin
        if (sel) rank_r <= '0;
        else if (younger) rank_r <= rank_r + 1'b1;
      end
      CELL_INSERT: begin
        if (sel) rank_r <= '0;
        else if (valid_r) rank_r <= rank_r + 1'b1;
      end
      default: begin
      end
    endcase
    if ((cmd.op == CELL_INSERT || cmd.op == CELL_REPLACE) && sel) tag_r <= cmd.key_tag;
  end

endmodule

>>> sv/lwsc_stack_cell.sv
// one entry of the free slot stack, shifting to its neighbors on push and pop
// depends on lwsc_pkg
`timescale 1ns / 1ps
module lwsc_stack_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [lwsc_pkg::SLOT_W-1:0]  rst_val,
  input  logic                         push,
  input  logic                         pop,
  input  logic [lwsc_pkg::SLOT_W-1:0]  from_above,
  input  logic [lwsc_pkg::SLOT_W-1:0]  from_below,
  output logic [lwsc_pkg::SLOT_W-1:0]  entry
);
  import lwsc_pkg::*;

  logic [SLOT_W-1:0] entry_r;

  assign entry = entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= rst_val;
    end else if (push) begin
      entry_r <= from_above;
    end else if (pop) begin
      entry_r <= from_below;
    end
  end

endmodule

>>> verif/testbench.sv
// self-checking testbench for lru_writeback_sector_cache: stream stimulus with random gaps
// depends on lwsc_pkg and the top level; predicts every result with an in-bench cache model
`timescale 1ns / 1ps
module testbench;
  import lwsc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;   // sector
  logic [1:0] in_tuser = '0;    // kind
  logic in_tlast = 1'b0;        // request_end
  logic out_tvalid;
  logic out_tready = 1'b0;
  // out_tdata from bit 0: hit, slot, start_sector, run_count, refused,
  // request_end_res, zero pad
  logic [55:0] out_tdata;
  logic [1:0] out_tuser;        // op
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic cfg_addr = REG_ENABLED;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  lru_writeback_sector_cache DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // one expected result transaction
  typedef struct {
    logic [1:0] op;
    logic hit;
    logic [SLOT_W-1:0] slot;
    logic [31:0] start;
    logic [9:0] cnt;
    logic refused;
    logic rend;
    logic last;
  } cache_result_t;

  cache_result_t pending_results[$];

  // cache image kept by the bench
  logic en_q;
  logic [9:0] run_limit_q;
  logic [31:0] tag_q [CAPACITY];
  logic valid_q [CAPACITY];
  logic dirty_q [CAPACITY];
  int rank_q [CAPACITY];
  int free_stk [CAPACITY];
  int free_cnt;

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int wbacks_seen = 0;
  int hits_seen = 0;
  int idle_cycles = 0;

  function automatic void push_result(logic [1:0] op, logic hit, int slot, logic [31:0] start,
                                      int cnt, logic refused, logic rend);
    cache_result_t r;
    r.op = op; r.hit = hit; r.slot = slot[SLOT_W-1:0]; r.start = start;
    r.cnt = cnt[9:0]; r.refused = refused; r.rend = rend; r.last = 1'b0;
    pending_results.push_back(r);
  endfunction

  function automatic int lookup_slot(logic [31:0] tag);
    for (int s = 0; s < CAPACITY; s++)
      if (valid_q[s] && tag_q[s] == tag) return s;
    return -1;
  endfunction

  function automatic int lru_slot();
    int best;
    best = -1;
    for (int s = 0; s < CAPACITY; s++)
      if (valid_q[s] && (best < 0 || rank_q[s] > rank_q[best])) best = s;
    return best;
  endfunction

  function automatic void promote(int s, bit all_age);
    for (int t = 0; t < CAPACITY; t++)
      if (valid_q[t] && t != s && (all_age || rank_q[t] < rank_q[s])) rank_q[t]++;
    rank_q[s] = 0;
  endfunction

  // write back the dirty run that starts at the victim's sector
  function automatic void write_back(int s);
    int lim, i, t;
    logic [31:0] base;
    if (!dirty_q[s]) return;
    base = tag_q[s];
    lim = int'(run_limit_q);
    if (lim > RUN_MAX) lim = RUN_MAX;
    if (lim > CAPACITY) lim = CAPACITY;
    if (lim == 0) lim = 1;
    for (i = 0; i < lim; i++) begin
      t = lookup_slot(base + 32'(i));
      if (t < 0 || !dirty_q[t]) break;
      dirty_q[t] = 1'b0;
    end
    push_result(OP_WBACK, 1'b0, s, base, i, 1'b0, 1'b0);
  endfunction

  function automatic void predict_access(logic [1:0] kind, logic [31:0] sector, logic rend);
    int s, n0;
    logic hit;
    n0 = pending_results.size();
    if (!en_q) begin
      push_result(kind == KIND_FLUSH ? OP_FLUSH : OP_ACCESS, 1'b0, 0, 32'd0, 0, 1'b1,
                  kind == KIND_FLUSH ? 1'b0 : rend);
    end else if (kind == KIND_FLUSH) begin
      s = lru_slot();
      while (s >= 0) begin
        write_back(s);
        valid_q[s] = 1'b0;
        dirty_q[s] = 1'b0;
        if (free_cnt < CAPACITY) free_stk[free_cnt++] = s;
        s = lru_slot();
      end
      push_result(OP_FLUSH, 1'b0, 0, 32'd0, 0, 1'b0, 1'b0);
    end else begin
      s = lookup_slot(sector);
      hit = (s >= 0);
      if (hit) begin
        promote(s, 0);
      end else begin
        if (free_cnt > 0) begin
          free_cnt--;
          s = free_stk[free_cnt] % CAPACITY;
          tag_q[s] = sector; dirty_q[s] = 1'b0; valid_q[s] = 1'b1;
          promote(s, 1);
        end else begin
          s = lru_slot();
          if (s < 0) s = 0;
          write_back(s);
          tag_q[s] = sector; dirty_q[s] = 1'b0; valid_q[s] = 1'b1;
          promote(s, 0);
        end
        if (kind != KIND_WRITE) push_result(OP_FILL, 1'b0, s, sector, 1, 1'b0, 1'b0);
      end
      if (kind != KIND_READ) dirty_q[s] = 1'b1;
      push_result(OP_ACCESS, hit, s, 32'd0, 0, 1'b0, rend);
    end
    // the final result of this item carries last
    pending_results[pending_results.size() - 1].last = 1'b1;
    if (pending_results.size() <= n0) errors++;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
             results_seen, what, got, want);
  endtask

  // result checker: compare each out transaction with the oldest expectation
  always @(posedge clk) begin
    cache_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, op", 32'(out_tuser), 32'd0);
      end else begin
        e = pending_results[0];
        pending_results.delete(0);
        if (out_tuser !== e.op) report_mismatch("op", 32'(out_tuser), 32'(e.op));
        if (out_tdata[0] !== e.hit) report_mismatch("hit", 32'(out_tdata[0]), 32'(e.hit));
        if (out_tdata[5:1] !== e.slot)
          report_mismatch("slot", 32'(out_tdata[5:1]), 32'(e.slot));
        if (out_tdata[37:6] !== e.start)
          report_mismatch("start_sector", out_tdata[37:6], e.start);
        if (out_tdata[47:38] !== e.cnt)
          report_mismatch("run_count", 32'(out_tdata[47:38]), 32'(e.cnt));
        if (out_tdata[48] !== e.refused)
          report_mismatch("refused", 32'(out_tdata[48]), 32'(e.refused));
        if (out_tdata[49] !== e.rend)
          report_mismatch("request_end_res", 32'(out_tdata[49]), 32'(e.rend));
        if (out_tdata[55:50] !== 6'd0)
          report_mismatch("pad", 32'(out_tdata[55:50]), 32'd0);
        if (out_tlast !== e.last) report_mismatch("last", 32'(out_tlast), 32'(e.last));
        if (e.op == OP_WBACK) wbacks_seen++;
        if (e.op == OP_ACCESS && e.hit) hits_seen++;
      end
      results_seen++;
    end
  end

  // watchdog: cycles with no transaction on either stream
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 8000) begin
      $display("timeout: no transaction for %0d cycles", idle_cycles);
      $display("[lru_writeback_sector_cache] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stalls, some long, with long stretches of steady ready
  initial begin
    int n;
    @(negedge clk);
    forever begin
      out_tready = 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      n = random_gap();
      if (n > 0) begin
        out_tready = 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  end

  // send one item; inputs move on falling edges, acceptance seen on rising edges
  task automatic send_item(logic [1:0] kind, logic [31:0] sector, logic rend);
    int gap;
    in_tvalid = 1'b1;
    in_tuser = kind;
    in_tdata = sector;
    in_tlast = rend;
    do @(posedge clk); while (!in_tready);
    predict_access(kind, sector, rend);
    items_sent++;
    @(negedge clk);
    gap = random_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // wait until every expected result is back, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic addr, logic [LIMIT_W-1:0] value);
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_wdata = value;
    if (addr == REG_ENABLED) en_q = value[0];
    else run_limit_q = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // every request refused while the cache is off
  task automatic test_disabled();
    send_item(KIND_READ, 32'h0000_0000, 1'b1);
    send_item(KIND_WRITE, 32'hFFFF_FFFF, 1'b0);
    send_item(KIND_MODIFY, 32'h1234_5678, 1'b1);
    send_item(KIND_FLUSH, 32'hDEAD_BEEF, 1'b1);
    drain();
  endtask

  // hits, misses, every kind, wrap of a dirty run past the top sector
  task automatic test_directed();
    write_reg(REG_ENABLED, 10'd1);
    write_reg(REG_LIMIT, 10'd32);
    send_item(KIND_READ, 32'h0000_0010, 1'b0);    // read miss with fill
    send_item(KIND_READ, 32'h0000_0010, 1'b1);    // read hit
    send_item(KIND_WRITE, 32'h0000_0011, 1'b0);   // write miss, no fill
    send_item(KIND_WRITE, 32'h0000_0011, 1'b1);   // write hit
    send_item(KIND_MODIFY, 32'h0000_0012, 1'b1);  // modify miss
    send_item(KIND_MODIFY, 32'h0000_0010, 1'b0);  // modify hit
    send_item(KIND_WRITE, 32'hFFFF_FFFE, 1'b0);
    send_item(KIND_WRITE, 32'hFFFF_FFFF, 1'b0);
    send_item(KIND_WRITE, 32'h0000_0000, 1'b1);   // run wraps to zero
    send_item(KIND_READ, 32'hAAAA_5555, 1'b0);
    send_item(KIND_READ, 32'h5555_AAAA, 1'b1);
    send_item(KIND_FLUSH, 32'hFFFF_FFFF, 1'b1);   // flush writes back every run
    send_item(KIND_FLUSH, 32'h0, 1'b0);           // flush of an empty cache
    // fill all slots dirty, then force evictions of consecutive dirty runs
    for (int i = 0; i < 34; i++)
      send_item(i[0] ? KIND_WRITE : KIND_MODIFY, 32'h100 + i, 1'b1);
    drain();
  endtask

  // random traffic under one run limit: windowed sectors for hits and runs
  task automatic test_random(int count, logic [LIMIT_W-1:0] limit);
    logic [31:0] base, sec;
    logic [1:0] kind;
    int r;
    write_reg(REG_LIMIT, limit);
    base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFE8 : $urandom;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      kind = (r < 30) ? KIND_READ : (r < 65) ? KIND_WRITE : (r < 97) ? KIND_MODIFY : KIND_FLUSH;
      sec = ($urandom_range(0, 9) == 0) ? $urandom : base + $urandom_range(0, 44);
      send_item(kind, sec, 1'($urandom_range(0, 1)));
    end
    drain();
  endtask

  initial begin
    en_q = 1'b0;
    run_limit_q = 10'd32;
    for (int i = 0; i < CAPACITY; i++) begin
      tag_q[i] = '0; valid_q[i] = 1'b0; dirty_q[i] = 1'b0; rank_q[i] = 0; free_stk[i] = i;
    end
    free_cnt = CAPACITY;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    repeat (80) @(negedge clk);   // room for any clearing pass after reset

    test_disabled();
    test_directed();
    test_random(30, 10'd0);       // zero limit acts as one
    test_random(30, 10'd1);
    test_random(30, 10'd512);
    test_random(30, 10'd1023);
    test_random(30, 10'd3);
    write_reg(REG_ENABLED, 10'd0);
    test_random(6, 10'd32);       // refused again after disabling
    write_reg(REG_ENABLED, 10'd1);
    test_random(20, 10'd32);

    $display("covered %0d items, %0d results, %0d hits, %0d write-back runs",
             items_sent, results_seen, hits_seen, wbacks_seen);
    $display("run limits 0, 1, 3, 32, 512, 1023; enable toggled off and on");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[lru_writeback_sector_cache] OK");
    end else begin
      $display("[lru_writeback_sector_cache] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
sv/lwsc_pkg.sv
sv/lwsc_slot_cell.sv
sv/lwsc_stack_cell.sv
sv/lru_writeback_sector_cache.sv
verif/testbench.sv
